### design/bb3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_pkg
// shared types, widths and helpers of the 3x3 rgb box blur
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int RCNT_W     = ROW_W + 1;
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int CNT_W      = 22;
  localparam int SUM_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [FW_W-1:0]  FW_RESET    = FW_W'(800);
  localparam logic [FH_W-1:0]  FH_RESET    = FH_W'(600);
  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(800 * 600);

  // floor(x / 9) for x below 2^SUM_W as (x * 7282) >> 16
  localparam int DIV9_MUL_W = 13;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = DIV9_MUL_W'(7282);
  localparam int DIV9_SHIFT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // control of one beat between the counters and the window
  typedef struct packed {
    logic             has_out;
    logic             use_old;
    logic [2:0]       row_mask;
    logic [2:0]       col_mask;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
    rgb_t             pix;
  } s1_t;

  // window sums waiting for the divide
  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } s2_t;

  function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+DIV9_MUL_W-1:0] p;
    p = (SUM_W+DIV9_MUL_W)'(s) * (SUM_W+DIV9_MUL_W)'(DIV9_MUL);
    return p[DIV9_SHIFT +: 8];
  endfunction

endpackage
`default_nettype wire

### design/bb3_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_in_if
// input pixel channel: valid/ready with operation and rgb payload
// ----------------------------------------------------------------------------
interface bb3_in_if import bb3_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, operation, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, operation, in_red, in_green, in_blue, output ready);
endinterface
`default_nettype wire

### design/bb3_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_out_if
// output pixel channel: valid/ready with blurred rgb and position
// ----------------------------------------------------------------------------
interface bb3_out_if import bb3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [7:0]       out_red;
  logic [7:0]       out_green;
  logic [7:0]       out_blue;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic             frame_done;

  modport source (output valid, out_red, out_green, out_blue, out_col, out_row,
                  frame_done, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_col, out_row,
                  frame_done, output ready);
endinterface
`default_nettype wire

### design/bb3_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_ctrl
// frame registers, position counters and per-beat window control
// ----------------------------------------------------------------------------
module bb3_ctrl import bb3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  acc_i,
  input  op_e                   op_i,
  input  rgb_t                  pix_i,
  input  logic                  s1_adv_i,
  output logic                  mem_en_o,
  output logic [COL_W-1:0]      mem_addr_o,
  output rgb_t                  mem_wdata_o,
  output logic                  s1_valid_o,
  output s1_t                   s1_o
);

  localparam int CW1 = COL_W + 1;
  localparam int PW  = FW_W + FH_W;

  logic [FW_W-1:0]   fw_q, fw_d, fw_new;
  logic [FH_W-1:0]   fh_q, fh_d, fh_new;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [PW-1:0]     prod;
  logic [COL_W-1:0]  col_q;
  logic [RCNT_W-1:0] row_q;
  logic [CNT_W-1:0]  emit_q;
  logic              s1_valid_q;
  s1_t               s1_q, s1_d;

  logic              drain, work, due, edge_out, wrap;
  logic [RCNT_W-1:0] orow_full;
  logic [ROW_W-1:0]  orow;
  logic [COL_W-1:0]  ocol;
  logic [FW_W-1:0]   fw_m1;
  logic [CW1-1:0]    col_inc;
  rgb_t              pix;

  // clamp written values into the supported range
  always_comb begin
    fw_new = cfg_data_i[FW_W-1:0];
    if (fw_new < FW_W'(3)) begin
      fw_new = FW_W'(3);
    end else if (fw_new > FW_W'(MAX_WIDTH)) begin
      fw_new = FW_W'(MAX_WIDTH);
    end
    fh_new = cfg_data_i[FH_W-1:0];
    if (fh_new < FH_W'(3)) begin
      fh_new = FH_W'(3);
    end
    fw_d = fw_q;
    fh_d = fh_q;
    if (cfg_we_i && cfg_reg_e'(cfg_idx_i) == REG_FRAME_WIDTH) begin
      fw_d = fw_new;
    end
    if (cfg_we_i && cfg_reg_e'(cfg_idx_i) == REG_FRAME_HEIGHT) begin
      fh_d = fh_new;
    end
    prod    = PW'(fw_d) * PW'(fh_d);
    total_d = prod[CNT_W-1:0];
  end

  always_comb begin
    drain     = row_q >= {1'b0, fh_q};
    work      = acc_i && (drain || op_i == OP_PIXEL);
    pix       = drain ? '0 : pix_i;
    due       = (row_q >= RCNT_W'(2) || (row_q == RCNT_W'(1) && col_q != '0)) &&
                (emit_q < total_q);
    edge_out  = due && (col_q == '0);
    orow_full = row_q - (edge_out ? RCNT_W'(2) : RCNT_W'(1));
    orow      = orow_full[ROW_W-1:0];
    fw_m1     = fw_q - FW_W'(1);
    ocol      = edge_out ? fw_m1[COL_W-1:0] : col_q - COL_W'(1);
    col_inc   = {1'b0, col_q} + CW1'(1);
    wrap      = col_inc >= CW1'(fw_q);

    s1_d.has_out  = due;
    s1_d.use_old  = edge_out;
    s1_d.row_mask = {({1'b0, orow} + RCNT_W'(1)) < {1'b0, fh_q}, 1'b1, orow != '0};
    s1_d.col_mask = (!edge_out && ocol != '0) ? 3'b111 : 3'b110;
    s1_d.row      = orow;
    s1_d.col      = ocol;
    s1_d.done     = due && (emit_q + CNT_W'(1) == total_q);
    s1_d.pix      = pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= FW_RESET;
      fh_q       <= FH_RESET;
      total_q    <= TOTAL_RESET;
      col_q      <= '0;
      row_q      <= '0;
      emit_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        // any register write restarts the frame
        fw_q    <= fw_d;
        fh_q    <= fh_d;
        total_q <= total_d;
        col_q   <= '0;
        row_q   <= '0;
        emit_q  <= '0;
      end else if (work) begin
        if (s1_d.done) begin
          col_q  <= '0;
          row_q  <= '0;
          emit_q <= '0;
        end else begin
          col_q  <= wrap ? '0 : col_inc[COL_W-1:0];
          row_q  <= wrap ? row_q + RCNT_W'(1) : row_q;
          emit_q <= emit_q + CNT_W'(due);
        end
      end
      if (work) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      s1_q <= s1_d;
    end
  end

  assign mem_en_o    = work;
  assign mem_addr_o  = col_q;
  assign mem_wdata_o = pix;
  assign s1_valid_o  = s1_valid_q;
  assign s1_o        = s1_q;

endmodule
`default_nettype wire

### design/bb3_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_line_buf
// two line memories holding the previous row and the row before it
// ----------------------------------------------------------------------------
module bb3_line_buf import bb3_pkg::*; (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] addr_i,
  input  rgb_t             wdata_i,
  input  logic             shift_i,
  output rgb_t             top_o,
  output rgb_t             mid_o
);

  rgb_t             store_a [MAX_WIDTH];
  rgb_t             store_b [MAX_WIDTH];
  rgb_t             top_q;
  rgb_t             mid_q;
  logic [COL_W-1:0] addr_q;

  // read-before-write on newest row, older row moves down when the beat advances
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      store_a[addr_i] <= wdata_i;
      mid_q           <= store_a[addr_i];
      top_q           <= store_b[addr_i];
      addr_q          <= addr_i;
    end
    if (shift_i) begin
      store_b[addr_q] <= mid_q;
    end
  end

  assign top_o = top_q;
  assign mid_o = mid_q;

endmodule
`default_nettype wire

### design/bb3_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_window
// 3x3 window registers and masked per-channel window sums
// ----------------------------------------------------------------------------
module bb3_window import bb3_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clear_i,
  input  logic s1_adv_i,
  input  logic s2_adv_i,
  input  s1_t  s1_i,
  input  rgb_t top_i,
  input  rgb_t mid_i,
  output logic s2_valid_o,
  output s2_t  s2_o
);

  rgb_t             win_q   [3][3];
  rgb_t             shifted [3][3];
  rgb_t             pick    [3][3];
  rgb_t             ncol    [3];
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic             s2_valid_q;
  s2_t              s2_q;

  always_comb begin
    ncol[0] = top_i;
    ncol[1] = mid_i;
    ncol[2] = s1_i.pix;
    for (int r = 0; r < 3; r++) begin
      shifted[r][0] = win_q[r][1];
      shifted[r][1] = win_q[r][2];
      shifted[r][2] = ncol[r];
    end
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        // right-edge output of the row above sums the window before the shift
        pick[r][c] = s1_i.use_old ? win_q[r][c] : shifted[r][c];
        if (s1_i.row_mask[r] && s1_i.col_mask[c]) begin
          sum_r = sum_r + SUM_W'(pick[r][c].red);
          sum_g = sum_g + SUM_W'(pick[r][c].green);
          sum_b = sum_b + SUM_W'(pick[r][c].blue);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
      s2_valid_q <= 1'b0;
    end else begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (clear_i || (s1_adv_i && s1_i.done)) begin
            win_q[r][c] <= '0;
          end else if (s1_adv_i) begin
            win_q[r][c] <= shifted[r][c];
          end
        end
      end
      if (s1_adv_i) begin
        s2_valid_q <= s1_i.has_out;
      end else if (s2_adv_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_i) begin
      s2_q.red   <= sum_r;
      s2_q.green <= sum_g;
      s2_q.blue  <= sum_b;
      s2_q.row   <= s1_i.row;
      s2_q.col   <= s1_i.col;
      s2_q.done  <= s1_i.done;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_o       = s2_q;

endmodule
`default_nettype wire

### design/box_blur_3x3_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// streaming 3x3 box blur on 8-bit rgb pixels in raster order
// ----------------------------------------------------------------------------
// Takes one beat per clock, sustained unless the output stalls, and gives
// at most one blurred pixel per beat. The beat that completes a window
// comes one row and one pixel after its center pixel; the result then
// passes the counter, window sum and divide-by-nine registers. The rate is
// set by the two 1024 x 24 line memories, each read and written once per
// beat, and by the single window sum per beat. Out-of-frame neighbors count
// as zero while the divisor stays nine. After the last pixel of a frame,
// width + 1 flush beats drain the remaining outputs, the last one marked
// with frame_done; a flush seen before the frame is complete is taken and
// dropped, and a pixel sent during the drain acts as a flush. The line
// memories need no clearing pass after reset. Writing frame_width (clamped
// to 3..1024) or frame_height (at least 3) restarts the frame; the user
// must do it only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb import bb3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bb3_in_if.sink                pix_i,
  bb3_out_if.source             pix_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // handshake chain: counters -> window sum -> divide / output register
  logic       acc;
  logic       s1_valid, s2_valid, out_valid_q;
  logic       out_free, s2_free, s1_adv, s2_adv;
  s1_t        s1;
  s2_t        s2;
  rgb_t       in_pix;
  logic       mem_en;
  logic [COL_W-1:0] mem_addr;
  rgb_t       mem_wdata, top, mid;

  // output register payload
  logic [7:0]       red_q, green_q, blue_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             done_q;

  assign out_free    = !out_valid_q || pix_o.ready;
  assign s2_free     = !s2_valid || out_free;
  assign s1_adv      = s1_valid && s2_free;
  assign s2_adv      = s2_valid && out_free;
  assign pix_i.ready = !s1_valid || s2_free;
  assign acc         = pix_i.valid && pix_i.ready;

  assign in_pix.red   = pix_i.in_red;
  assign in_pix.green = pix_i.in_green;
  assign in_pix.blue  = pix_i.in_blue;

  // frame registers, position counters, beat classification
  bb3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .op_i        (op_e'(pix_i.operation)),
    .pix_i       (in_pix),
    .s1_adv_i    (s1_adv),
    .mem_en_o    (mem_en),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1)
  );

  // previous two rows, read at the column of the accepted beat
  bb3_line_buf u_line_buf (
    .clk_i   (clk_i),
    .rd_en_i (mem_en),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .shift_i (s1_adv),
    .top_o   (top),
    .mid_o   (mid)
  );

  // window shift and masked sums
  bb3_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (cfg_we_i),
    .s1_adv_i   (s1_adv),
    .s2_adv_i   (s2_adv),
    .s1_i       (s1),
    .top_i      (top),
    .mid_i      (mid),
    .s2_valid_o (s2_valid),
    .s2_o       (s2)
  );

  // output register, divide by nine on the way in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      red_q   <= div9(s2.red);
      green_q <= div9(s2.green);
      blue_q  <= div9(s2.blue);
      col_q   <= s2.col;
      row_q   <= s2.row;
      done_q  <= s2.done;
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.out_red    = red_q;
  assign pix_o.out_green  = green_q;
  assign pix_o.out_blue   = blue_q;
  assign pix_o.out_col    = col_q;
  assign pix_o.out_row    = row_q;
  assign pix_o.frame_done = done_q;

endmodule
`default_nettype wire

### tb/sv/blur_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur_check_pkg
// pixel-exact prediction and result checking for the 3x3 rgb box blur
// ----------------------------------------------------------------------------
package blur_check_pkg;
  import bb3_pkg::*;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             done;
  } blur_px_t;

  class blur_scoreboard;
    // copies of the two line memories: previous row and the row before it
    rgb_t row_above [MAX_WIDTH];
    rgb_t row_above2 [MAX_WIDTH];
    rgb_t win [9];
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned emitted;
    int unsigned fw = 800;
    int unsigned fh = 600;
    blur_px_t blurred_q [$];
    int unsigned errors;
    int unsigned shown;

    function new();
      begin_frame();
    endfunction

    function void begin_frame();
      foreach (win[i]) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      emitted = 0;
    endfunction

    function void apply_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
      int unsigned v;
      if (idx == REG_FRAME_WIDTH) begin
        v = value[FW_W-1:0];
        if (v < 3) v = 3;
        if (v > MAX_WIDTH) v = MAX_WIDTH;
        fw = v;
      end else begin
        v = value[FH_W-1:0];
        if (v < 3) v = 3;
        fh = v;
      end
      begin_frame();
    endfunction

    // window rows that lie inside the frame around output row orow
    function bit [2:0] rows_in_frame(int unsigned orow);
      bit [2:0] m;
      m = 3'b010;
      if (orow > 0) m[0] = 1'b1;
      if (orow + 1 < fh) m[2] = 1'b1;
      return m;
    endfunction

    function blur_px_t window_avg(bit [2:0] rows_on, bit [2:0] cols_on,
                                  int unsigned orow, int unsigned ocol, bit done);
      int unsigned sum_r;
      int unsigned sum_g;
      int unsigned sum_b;
      blur_px_t px;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (rows_on[r] && cols_on[c]) begin
            sum_r += win[r*3+c].red;
            sum_g += win[r*3+c].green;
            sum_b += win[r*3+c].blue;
          end
        end
      end
      px.red   = 8'(sum_r / 9);
      px.green = 8'(sum_g / 9);
      px.blue  = 8'(sum_b / 9);
      px.col   = COL_W'(ocol);
      px.row   = ROW_W'(orow);
      px.done  = done;
      return px;
    endfunction

    function void note_input(op_e op, rgb_t px);
      int unsigned total;
      int unsigned r;
      int unsigned c;
      rgb_t pix;
      rgb_t top;
      rgb_t mid;
      bit due;
      bit done;
      bit got;
      total = fw * fh;
      r = row_cnt;
      c = col_cnt;
      pix = '0;
      done = 1'b0;
      got = 1'b0;
      if (r < fh) begin
        // early flush is dropped
        if (op == OP_FLUSH) return;
        pix = px;
      end
      due = (r >= 2 || (r == 1 && c >= 1)) && emitted < total;
      // right edge of the row before, from the window as it stands
      if (due && c == 0) begin
        done = (emitted + 1 == total);
        blurred_q.push_back(window_avg(rows_in_frame(r - 2), 3'b110, r - 2, fw - 1, done));
        got = 1'b1;
      end
      top = row_above2[c];
      mid = row_above[c];
      row_above2[c] = mid;
      row_above[c] = pix;
      for (int k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = pix;
      if (due && c >= 1) begin
        done = (emitted + 1 == total);
        blurred_q.push_back(window_avg(rows_in_frame(r - 1), (c > 1) ? 3'b111 : 3'b110,
                                       r - 1, c - 1, done));
        got = 1'b1;
      end
      c++;
      if (c >= fw) begin
        c = 0;
        r++;
      end
      col_cnt = c;
      row_cnt = r;
      if (got) begin
        emitted++;
        if (done) begin_frame();
      end
    endfunction

    function void report(string field, blur_px_t want, logic [15:0] exp_v,
                         logic [15:0] act_v);
      errors++;
      if (shown < 40) begin
        shown++;
        $display("%0t ns: %s mismatch at row %0d col %0d, expected %0d, actual %0d",
                 $time, field, want.row, want.col, exp_v, act_v);
      end
    endfunction

    function void check_result(blur_px_t got);
      blur_px_t want;
      if (blurred_q.size() == 0) begin
        errors++;
        if (shown < 40) begin
          shown++;
          $display("%0t ns: result at row %0d col %0d with none expected, expected none, actual %h",
                   $time, got.row, got.col, got);
        end
        return;
      end
      want = blurred_q.pop_front();
      if (want.red !== got.red) report("out_red", want, want.red, got.red);
      if (want.green !== got.green) report("out_green", want, want.green, got.green);
      if (want.blue !== got.blue) report("out_blue", want, want.blue, got.blue);
      if (want.col !== got.col) report("out_col", want, want.col, got.col);
      if (want.row !== got.row) report("out_row", want, want.row, got.row);
      if (want.done !== got.done) report("frame_done", want, want.done, got.done);
    endfunction

    function int unsigned pending();
      return blurred_q.size();
    endfunction
  endclass

endpackage

### tb/sv/tb_box_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb
// self-checking bench for the streaming 3x3 rgb box blur
// ----------------------------------------------------------------------------
// Streams raster frames through the blur, predicts every blurred pixel with
// its position and frame end mark, and compares each output beat in order.
// Covers early flushes at the reset frame size, clamped register values,
// early and late flush beats, pixels during the drain, cut-off frames, a long
// output hold that backs the block up, and register writes at both ends of
// the frame size ranges.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb;
  import bb3_pkg::*;
  import blur_check_pkg::*;

  localparam int unsigned PIPE_SLACK     = 8;    // wait after the last predicted pixel for the pipe to settle
  localparam int unsigned HOLD_LEN       = 200;  // long output hold to fill the block
  localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles without any beat

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bb3_in_if  pix_in ();
  bb3_out_if pix_out ();

  box_blur_3x3_rgb dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_in),
    .pix_o      (pix_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  blur_scoreboard blur_sb;

  // idle rates of both sides, in percent of cycles
  int unsigned src_idle_pct = 25;
  int unsigned snk_idle_pct = 63;

  // output hold requests: main bumps hold_asks, the sink side counts cycles
  int unsigned hold_asks    = 0;
  int unsigned hold_granted = 0;
  int unsigned hold_left    = 0;

  int unsigned scored_items = 0;
  bit          frame_open   = 1'b0;  // a frame was cut off and needs a restart

  // directed pixels: full scale, zero and alternating bit patterns
  rgb_t corner_px [9] = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                          24'h000000, 24'hFFFFFF, 24'hAA55AA,
                          24'h55AA55, 24'hFFFFFF, 24'hFFFFFF};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // beat monitors; values read here are the ones present before the edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && pix_in.valid && pix_in.ready) begin
      blur_sb.note_input(op_e'(pix_in.operation),
                         {pix_in.in_red, pix_in.in_green, pix_in.in_blue});
    end
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      blur_sb.check_result({pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                            pix_out.out_col, pix_out.out_row, pix_out.frame_done});
    end
  end

  // ---------------------------------------------------------------------------
  // sink side: random stalls, or a long hold when main asks for one
  // ---------------------------------------------------------------------------
  initial begin
    pix_out.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_granted != hold_asks) begin
        hold_granted = hold_asks;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without a beat on either side ends the run
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL box_blur_3x3_rgb");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one beat, with a random gap first; valid stays high on return so
  // back-to-back beats never see a low-high pair in one step
  task automatic send_beat(op_e op, rgb_t px);
    if ($urandom_range(99) < src_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    pix_in.valid     <= 1'b1;
    pix_in.operation <= op;
    {pix_in.in_red, pix_in.in_green, pix_in.in_blue} <= px;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
  endtask

  // stop offering, wait for every predicted pixel, then let the pipe settle
  task automatic drain_wait();
    pix_in.valid <= 1'b0;
    @(posedge clk_i);
    while (blur_sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  // one register write; the extra edge keeps writes from sharing a step
  task automatic cfg_write(cfg_reg_e idx, int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    blur_sb.apply_reg(idx, CFG_DATA_W'(value));
    @(posedge clk_i);
  endtask

  // frame pixels, with an occasional flush slipped in early (dropped by the block)
  task automatic send_pixels(int unsigned n, int unsigned junk_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < junk_pct) send_beat(OP_FLUSH, 24'($urandom));
      send_beat(OP_PIXEL, 24'($urandom));
      scored_items++;
    end
  endtask

  // drain beats: mostly flush, some pixels that the block treats as flush
  task automatic send_drain(int unsigned n, int unsigned pix_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < pix_pct) begin
        send_beat(OP_PIXEL, 24'($urandom));
      end else begin
        send_beat(OP_FLUSH, 24'($urandom));
      end
      scored_items++;
    end
  endtask

  // one frame at the current size; a cut frame stops partway and is left open
  task automatic run_frame(bit cut, int unsigned junk_pct, int unsigned pix_pct);
    int unsigned npix;
    npix = blur_sb.fw * blur_sb.fh;
    if (cut) npix = $urandom_range(npix - 1, 1);
    send_pixels(npix, junk_pct);
    frame_open = cut;
    if (!cut) begin
      send_drain(blur_sb.fw + 1, pix_pct);
      // a flush after the drain lands in the next frame and is dropped
      if ($urandom_range(4) == 0) send_beat(OP_FLUSH, 24'($urandom));
    end
  endtask

  // small frame of random size; the size changes only with the block idle
  task automatic random_frame();
    int unsigned w_raw;
    int unsigned h_raw;
    int unsigned mode;
    w_raw = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 3);
    h_raw = $urandom_range(6, 3);
    // values below the minimum are clamped up by the block
    if ($urandom_range(7) == 0) w_raw = $urandom_range(2);
    if ($urandom_range(7) == 0) h_raw = $urandom_range(2);
    // 0: chain straight on, 1: new height only, 2: new width and height
    mode = frame_open ? $urandom_range(2, 1) : $urandom_range(2);
    if (mode != 0) begin
      drain_wait();
      if (mode == 2) cfg_write(REG_FRAME_WIDTH, w_raw);
      cfg_write(REG_FRAME_HEIGHT, h_raw);
    end
    run_frame($urandom_range(9) == 0, 6, 20);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    blur_sb = new();
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_FRAME_WIDTH;
    cfg_data_i       = '0;
    pix_in.valid     = 1'b0;
    pix_in.operation = OP_PIXEL;
    pix_in.in_red    = '0;
    pix_in.in_green  = '0;
    pix_in.in_blue   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset size 800 x 600: early flushes, then a short run inside the first row
    send_beat(OP_FLUSH, 24'hFFFFFF);
    send_beat(OP_FLUSH, 24'h000000);
    send_pixels(16, 0);
    drain_wait();

    // 3 x 3 through clamped writes: width bit 11 alone and height zero
    cfg_write(REG_FRAME_WIDTH, 12'h800);
    cfg_write(REG_FRAME_HEIGHT, 0);
    send_beat(OP_FLUSH, 24'hFFFFFF);
    foreach (corner_px[i]) send_beat(OP_PIXEL, corner_px[i]);
    // drain with a pixel in the middle acting as a flush
    send_beat(OP_FLUSH, 24'h000000);
    send_beat(OP_PIXEL, 24'hFFFFFF);
    send_beat(OP_FLUSH, 24'hFFFFFF);
    send_beat(OP_FLUSH, 24'h000000);
    // flush after the drain starts nothing
    send_beat(OP_FLUSH, 24'hFFFFFF);
    // all full scale: largest window sum
    repeat (9) send_beat(OP_PIXEL, 24'hFFFFFF);
    repeat (4) send_beat(OP_FLUSH, 24'h000000);
    frame_open = 1'b0;

    // random frames, idle pattern of the sender and receiver swapped midway
    scored_items = 0;
    src_idle_pct = 25;
    snk_idle_pct = 63;
    while (scored_items < 80) random_frame();
    src_idle_pct = 63;
    snk_idle_pct = 25;
    while (scored_items < 160) random_frame();
    src_idle_pct = 0;
    snk_idle_pct = 0;

    // output held for a long stretch while the sender keeps offering
    drain_wait();
    cfg_write(REG_FRAME_WIDTH, 24);
    cfg_write(REG_FRAME_HEIGHT, 4);
    hold_asks++;
    run_frame(1'b0, 6, 20);
    while (scored_items < 300) random_frame();

    // tallest frame, narrowest width: the first dozen rows
    drain_wait();
    cfg_write(REG_FRAME_WIDTH, 2);
    cfg_write(REG_FRAME_HEIGHT, 12'hFFF);
    send_pixels(blur_sb.fw * 12, 0);
    frame_open = 1'b1;

    // widest frame, width written above the limit: a short start of the first row
    drain_wait();
    cfg_write(REG_FRAME_WIDTH, 12'h7FF);
    cfg_write(REG_FRAME_HEIGHT, 3);
    send_pixels(12, 0);
    frame_open = 1'b1;

    drain_wait();
    if (blur_sb.errors == 0) begin
      $display("PASS box_blur_3x3_rgb");
    end else begin
      $display("FAIL box_blur_3x3_rgb");
    end
    $finish;
  end

endmodule

### box_blur_3x3_rgb.f
design/bb3_pkg.sv
design/bb3_in_if.sv
design/bb3_out_if.sv
design/bb3_ctrl.sv
design/bb3_line_buf.sv
design/bb3_window.sv
design/box_blur_3x3_rgb.sv
tb/sv/blur_check_pkg.sv
tb/sv/tb_box_blur_3x3_rgb.sv
